// ----- src/spat_pkg.sv -----
// Shared types, codes and constants for the segmented/paged address translator.
package spat_pkg;

    // Default store depths
    localparam int DESC_DEPTH_DEF = 256;
    localparam int PAGE_DEPTH_DEF = 1024;

    // Compare widths wide enough for the largest legal depth
    localparam int DESC_CMP_W = 14;
    localparam int PAGE_CMP_W = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DESC_CNT_W = 9;
    localparam int PAGE_CNT_W = 11;

    // Descriptor word layout
    localparam int DESC_PRESENT_BIT = 47;
    localparam int DESC_GRAN_BIT    = 55;

    // Page entry word as stored: frame in 20..1, present in 0
    localparam int PTE_W = 21;

    typedef enum logic [2:0] {
        ACT_LOAD_GLOBAL = 3'd0,
        ACT_LOAD_LOCAL  = 3'd1,
        ACT_LOAD_DIR    = 3'd2,
        ACT_LOAD_PAGE   = 3'd3,
        ACT_TRANSLATE   = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLOBAL_COUNT = 2'd0,
        CFG_LOCAL_COUNT  = 2'd1,
        CFG_DIR_COUNT    = 2'd2,
        CFG_PAGE_COUNT   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DESC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [9:0]  entry_index;
        logic [63:0] entry_value;
        logic [31:0] logical_address;
        logic [15:0] selector;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] physical_address;
        logic        fault;
    } out_beat_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // write the store named by the beat's action
        logic start;   // latch translate beat, read descriptor stores
        logic walk;    // limit check, linear add, directory/page reads
        logic finish;  // load result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_translate;
        logic is_load;
    } stat_t;

endpackage

// ----- src/segmented_paged_address_translator_core.sv -----
// Segmented and paged address translator: top level.
//
// Load beats (actions 0..3) write a descriptor into the global or local
// descriptor store, or an entry into the page directory or page table store;
// they are taken in the idle state, which they do not leave, and give no
// result. Unknown actions are taken and dropped. A translate beat (action 4)
// gives one result beat: the descriptor stores are read at the accept edge,
// the descriptor step runs the limit check and the base + offset add and reads
// the directory and page stores with the linear address, and the result step
// folds the presence bits into the result register. The input stays closed
// until then, so no new beat is taken while a translate is in flight. The
// result register parts the two channels, so a new beat is taken while a
// result waits; a second result stalls in its last step until the first is
// taken. The stores come up undefined and have no clearing pass: software
// loads every entry it will reach through the counts before translating.
// Counts are to be written by the user only while the block is idle; the
// block itself does not enforce it.
module segmented_paged_address_translator_core #(
    parameter int DESC_DEPTH = spat_pkg::DESC_DEPTH_DEF,
    parameter int PAGE_DEPTH = spat_pkg::PAGE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  spat_pkg::in_beat_t              in_data,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output spat_pkg::out_beat_t             out_data,
    // count register writes
    input  logic                            cfg_write,
    input  logic [spat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spat_pkg::CFG_DATA_W-1:0] cfg_data
);

    spat_pkg::cmd_t  cmd;
    spat_pkg::stat_t stat;

    // Sequencer: accept, descriptor step, result step
    spat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Stores, counts, checks and the result register
    spat_dpath #(
        .DESC_DEPTH (DESC_DEPTH),
        .PAGE_DEPTH (PAGE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

// ----- src/spat_ctrl.sv -----
// Sequencing state machine for the address translator.
module spat_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  spat_pkg::stat_t stat,
    output spat_pkg::cmd_t  cmd
);

    spat_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spat_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            spat_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.is_translate)
                    begin
                        cmd.start  = 1'b1;
                        state_next = spat_pkg::ST_DESC;
                    end
                    else if (stat.is_load)
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            spat_pkg::ST_DESC:
            begin
                cmd.walk   = 1'b1;
                state_next = spat_pkg::ST_DONE;
            end
            spat_pkg::ST_DONE:
            begin
                // hold here while the result register is still full
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = spat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spat_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- src/spat_dpath.sv -----
// Datapath: descriptor and page stores, count registers, checks and address add.
module spat_dpath #(
    parameter int DESC_DEPTH = spat_pkg::DESC_DEPTH_DEF,
    parameter int PAGE_DEPTH = spat_pkg::PAGE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spat_pkg::in_beat_t                in_data,
    input  spat_pkg::cmd_t                    cmd,
    output spat_pkg::stat_t                   stat,
    input  logic                              cfg_write,
    input  logic [spat_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spat_pkg::CFG_DATA_W-1:0]   cfg_data,
    output spat_pkg::out_beat_t               out_data
);

    localparam int DESC_AW = $clog2(DESC_DEPTH);
    localparam int PAGE_AW = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;
    localparam int DCW     = spat_pkg::DESC_CMP_W;
    localparam int PCW     = spat_pkg::PAGE_CMP_W;

    // Stores
    logic [63:0]                gdesc_mem [DESC_DEPTH];
    logic [63:0]                ldesc_mem [DESC_DEPTH];
    logic                       dir_mem   [PAGE_DEPTH];
    logic [spat_pkg::PTE_W-1:0] pte_mem   [PAGE_DEPTH];

    // Count registers
    logic [spat_pkg::DESC_CNT_W-1:0] global_count_reg;
    logic [spat_pkg::DESC_CNT_W-1:0] local_count_reg;
    logic [spat_pkg::PAGE_CNT_W-1:0] dir_count_reg;
    logic [spat_pkg::PAGE_CNT_W-1:0] page_count_reg;

    // Pipeline registers
    logic [31:0]                offset_reg;
    logic                       local_reg;
    logic                       sel_fault_reg;
    logic [63:0]                gdesc_rd_reg;
    logic [63:0]                ldesc_rd_reg;
    logic [11:0]                lin_low_reg;
    logic                       walk_fault_reg;
    logic                       dir_rd_reg;
    logic [spat_pkg::PTE_W-1:0] pte_rd_reg;
    spat_pkg::out_beat_t        out_data_reg;

    // Action decode
    assign stat.is_translate = (in_data.action == spat_pkg::ACT_TRANSLATE);
    assign stat.is_load      = (in_data.action == spat_pkg::ACT_LOAD_GLOBAL) ||
                               (in_data.action == spat_pkg::ACT_LOAD_LOCAL)  ||
                               (in_data.action == spat_pkg::ACT_LOAD_DIR)    ||
                               (in_data.action == spat_pkg::ACT_LOAD_PAGE);

    // Load slot range checks
    logic [DCW-1:0]     dslot_ext;
    logic               dslot_ok;
    logic [DESC_AW-1:0] dslot;
    logic               pslot_ok;
    logic [PAGE_AW-1:0] pslot;

    assign dslot_ext = DCW'(in_data.entry_index);
    assign dslot_ok  = dslot_ext < DCW'(DESC_DEPTH);
    assign dslot     = dslot_ext[DESC_AW-1:0];
    assign pslot_ok  = PCW'(in_data.entry_index) < PCW'(PAGE_DEPTH);
    assign pslot     = in_data.entry_index[PAGE_AW-1:0];

    // Selector decode
    logic [12:0]        sel_idx;
    logic [DCW-1:0]     sel_ext;
    logic               sel_in_depth;
    logic               g_ok;
    logic               l_ok;
    logic               sel_local;
    logic [DESC_AW-1:0] desc_addr;

    assign sel_idx      = in_data.selector[15:3];
    assign sel_local    = in_data.selector[2];
    assign sel_ext      = DCW'(sel_idx);
    assign sel_in_depth = sel_ext < DCW'(DESC_DEPTH);
    assign g_ok         = (sel_idx != 13'd0) && sel_in_depth &&
                          (sel_ext < DCW'(global_count_reg));
    assign l_ok         = sel_in_depth && (sel_ext < DCW'(local_count_reg));
    assign desc_addr    = sel_idx[DESC_AW-1:0];

    // Descriptor stage
    logic [63:0] desc;
    logic [19:0] lim20;
    logic [31:0] limit;
    logic [31:0] base;
    logic [31:0] lin;
    logic        dir_ok;
    logic        pg_ok;
    logic        walk_fault;

    assign desc   = local_reg ? ldesc_rd_reg : gdesc_rd_reg;
    assign lim20  = {desc[51:48], desc[15:0]};
    assign limit  = desc[spat_pkg::DESC_GRAN_BIT] ? {lim20, 12'hFFF} : {12'h000, lim20};
    assign base   = {desc[63:56], desc[39:16]};
    assign lin    = base + offset_reg;
    assign dir_ok = (PCW'(lin[31:22]) < dir_count_reg) &&
                    (PCW'(lin[31:22]) < PCW'(PAGE_DEPTH));
    assign pg_ok  = (PCW'(lin[21:12]) < page_count_reg) &&
                    (PCW'(lin[21:12]) < PCW'(PAGE_DEPTH));
    assign walk_fault = sel_fault_reg || !desc[spat_pkg::DESC_PRESENT_BIT] ||
                        (offset_reg > limit) || !dir_ok || !pg_ok;

    // Final stage
    logic fin_fault;
    assign fin_fault = walk_fault_reg || !dir_rd_reg || !pte_rd_reg[0];

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_count_reg <= '0;
            local_count_reg  <= '0;
            dir_count_reg    <= '0;
            page_count_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                spat_pkg::CFG_GLOBAL_COUNT: global_count_reg <= cfg_data[spat_pkg::DESC_CNT_W-1:0];
                spat_pkg::CFG_LOCAL_COUNT:  local_count_reg  <= cfg_data[spat_pkg::DESC_CNT_W-1:0];
                spat_pkg::CFG_DIR_COUNT:    dir_count_reg    <= cfg_data[spat_pkg::PAGE_CNT_W-1:0];
                spat_pkg::CFG_PAGE_COUNT:   page_count_reg   <= cfg_data[spat_pkg::PAGE_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Descriptor stores: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load && in_data.action == spat_pkg::ACT_LOAD_GLOBAL && dslot_ok)
        begin
            gdesc_mem[dslot] <= in_data.entry_value;
        end
        if (cmd.start)
        begin
            gdesc_rd_reg <= gdesc_mem[desc_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_data.action == spat_pkg::ACT_LOAD_LOCAL && dslot_ok)
        begin
            ldesc_mem[dslot] <= in_data.entry_value;
        end
        if (cmd.start)
        begin
            ldesc_rd_reg <= ldesc_mem[desc_addr];
        end
    end

    // Directory and page stores
    always_ff @(posedge clk)
    begin
        if (cmd.load && in_data.action == spat_pkg::ACT_LOAD_DIR && pslot_ok)
        begin
            dir_mem[pslot] <= in_data.entry_value[0];
        end
        if (cmd.walk)
        begin
            dir_rd_reg <= dir_mem[lin[22 +: PAGE_AW]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_data.action == spat_pkg::ACT_LOAD_PAGE && pslot_ok)
        begin
            pte_mem[pslot] <= {in_data.entry_value[31:12], in_data.entry_value[0]};
        end
        if (cmd.walk)
        begin
            pte_rd_reg <= pte_mem[lin[12 +: PAGE_AW]];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            offset_reg    <= in_data.logical_address;
            local_reg     <= sel_local;
            sel_fault_reg <= sel_local ? !l_ok : !g_ok;
        end
        if (cmd.walk)
        begin
            lin_low_reg    <= lin[11:0];
            walk_fault_reg <= walk_fault;
        end
        if (cmd.finish)
        begin
            out_data_reg.fault            <= fin_fault;
            out_data_reg.physical_address <= fin_fault ? 32'h0 :
                                             {pte_rd_reg[20:1], lin_low_reg};
        end
    end

    assign out_data = out_data_reg;

endmodule

// ----- src/spat_checker.sv -----
// Port-level checks for the address translator, bound to the top level.
module spat_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input spat_pkg::in_beat_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input spat_pkg::out_beat_t out_data
);

    logic tr_beat;
    logic other_beat;

    assign tr_beat    = in_valid && in_ready && (in_data.action == spat_pkg::ACT_TRANSLATE);
    assign other_beat = in_valid && in_ready && (in_data.action != spat_pkg::ACT_TRANSLATE);

    // A result beat held back keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // A faulted result carries a zero address
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fault |-> out_data.physical_address == 32'h0)
        else $error("faulted result with nonzero address");

    // A translate keeps the input closed during its descriptor and result steps
    a_tr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tr_beat |=> !in_ready ##1 !in_ready)
        else $error("input reopened during a translate");

    // Load and unknown beats produce no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        other_beat |=> !$rose(out_valid))
        else $error("result appeared after a non-translate beat");

endmodule

bind segmented_paged_address_translator_core spat_checker u_spat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the segmented/paged address translator core.
`timescale 1ns / 100ps

module testbench;

    // Run limits. The cap leaves a wide margin over the slowest correct run (about 650
    // beats, each with its sender gaps, the walk and a receiver stall, plus one long
    // hold-off).
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;   // result register plus the walk, rounded up

    // Actions past the last enum member; the block must take and drop them
    localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    spat_pkg::in_beat_t              in_data = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    spat_pkg::out_beat_t             out_data;
    logic                            cfg_write = 1'b0;
    logic [spat_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spat_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    segmented_paged_address_translator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block: stores, counts, and which entries were loaded.
    // The stores power up undefined, so every entry a translate can reach
    // through the counts is loaded before any translate goes out.
    // ------------------------------------------------------------------
    logic [63:0]                gdt_copy         [spat_pkg::DESC_DEPTH_DEF];
    logic [63:0]                ldt_copy         [spat_pkg::DESC_DEPTH_DEF];
    bit                         dir_present_copy [spat_pkg::PAGE_DEPTH_DEF];
    logic [spat_pkg::PTE_W-1:0] pte_copy         [spat_pkg::PAGE_DEPTH_DEF];
    bit                         gdt_loaded       [spat_pkg::DESC_DEPTH_DEF];
    bit                         ldt_loaded       [spat_pkg::DESC_DEPTH_DEF];
    bit                         dir_loaded       [spat_pkg::PAGE_DEPTH_DEF];
    bit                         pte_loaded       [spat_pkg::PAGE_DEPTH_DEF];

    int unsigned global_count    = 0;
    int unsigned local_count     = 0;
    int unsigned directory_count = 0;
    int unsigned page_count      = 0;

    spat_pkg::out_beat_t expected_translations [$];

    int unsigned mismatches           = 0;
    int unsigned translations_checked = 0;
    int unsigned faults_seen          = 0;
    int unsigned beats_sent           = 0;
    int unsigned cycle_count          = 0;

    // Idle percentages and the long receiver hold-off (counted down by the receiver)
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned ready_hold_left = 0;

    function automatic int unsigned clip_count(int unsigned cnt, int unsigned depth);
        return (cnt < depth) ? cnt : depth;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Descriptor with random filler in the bits the block ignores
    function automatic logic [63:0] make_descriptor(logic [31:0] base, logic [19:0] lim,
                                                    logic present, logic gran);
        logic [63:0] d;
        d = rand64();
        d[15:0]                       = lim[15:0];
        d[51:48]                      = lim[19:16];
        d[39:16]                      = base[23:0];
        d[63:56]                      = base[31:24];
        d[spat_pkg::DESC_PRESENT_BIT] = present;
        d[spat_pkg::DESC_GRAN_BIT]    = gran;
        return d;
    endfunction

    // Page word; a directory load only keeps bit 0 of the same layout
    function automatic logic [63:0] make_pte(logic [19:0] frame, logic present);
        logic [63:0] v;
        v = rand64();
        v[31:12] = frame;
        v[0]     = present;
        return v;
    endfunction

    function automatic spat_pkg::in_beat_t random_beat();
        spat_pkg::in_beat_t b;
        b.action          = 3'($urandom);
        b.entry_index     = 10'($urandom);
        b.entry_value     = rand64();
        b.logical_address = $urandom;
        b.selector        = 16'($urandom);
        return b;
    endfunction

    // Descriptor lookup, limit check, linear add, then the two-level page walk
    function automatic spat_pkg::out_beat_t translate_address(logic [31:0] offset,
                                                              logic [15:0] sel);
        spat_pkg::out_beat_t        r;
        logic [12:0]                slot;
        logic [63:0]                d;
        logic [31:0]                span;
        logic [31:0]                base;
        logic [31:0]                lin;
        logic [spat_pkg::PTE_W-1:0] pte;
        r.physical_address = '0;
        r.fault            = 1'b1;
        slot = sel[15:3];
        if (sel[2])
        begin
            if (slot >= clip_count(local_count, spat_pkg::DESC_DEPTH_DEF))
                return r;
            d = ldt_copy[slot];
        end
        else
        begin
            // global slot 0 is the null descriptor
            if (slot == 0 || slot >= clip_count(global_count, spat_pkg::DESC_DEPTH_DEF))
                return r;
            d = gdt_copy[slot];
        end
        if (!d[spat_pkg::DESC_PRESENT_BIT])
            return r;
        span = {12'h000, d[51:48], d[15:0]};
        if (d[spat_pkg::DESC_GRAN_BIT])
            span = {span[19:0], 12'hFFF};
        if (offset > span)
            return r;
        base = {d[63:56], d[39:16]};
        lin  = base + offset;   // wraps mod 2^32
        if (lin[31:22] >= clip_count(directory_count, spat_pkg::PAGE_DEPTH_DEF) ||
            !dir_present_copy[lin[31:22]])
            return r;
        if (lin[21:12] >= clip_count(page_count, spat_pkg::PAGE_DEPTH_DEF))
            return r;
        pte = pte_copy[lin[21:12]];
        if (!pte[0])
            return r;
        r.physical_address = {pte[20:1], lin[11:0]};
        r.fault            = 1'b0;
        return r;
    endfunction

    // Apply one accepted beat to the shadow; translates queue their result
    function automatic void absorb_beat(spat_pkg::in_beat_t b);
        case (b.action)
            spat_pkg::ACT_LOAD_GLOBAL:
                if (b.entry_index < spat_pkg::DESC_DEPTH_DEF)
                begin
                    gdt_copy[b.entry_index]   = b.entry_value;
                    gdt_loaded[b.entry_index] = 1'b1;
                end
            spat_pkg::ACT_LOAD_LOCAL:
                if (b.entry_index < spat_pkg::DESC_DEPTH_DEF)
                begin
                    ldt_copy[b.entry_index]   = b.entry_value;
                    ldt_loaded[b.entry_index] = 1'b1;
                end
            spat_pkg::ACT_LOAD_DIR:
                if (b.entry_index < spat_pkg::PAGE_DEPTH_DEF)
                begin
                    dir_present_copy[b.entry_index] = b.entry_value[0];
                    dir_loaded[b.entry_index]       = 1'b1;
                end
            spat_pkg::ACT_LOAD_PAGE:
                if (b.entry_index < spat_pkg::PAGE_DEPTH_DEF)
                begin
                    pte_copy[b.entry_index]   = {b.entry_value[31:12], b.entry_value[0]};
                    pte_loaded[b.entry_index] = 1'b1;
                end
            spat_pkg::ACT_TRANSLATE:
                expected_translations.insert(expected_translations.size(),
                    translate_address(b.logical_address, b.selector));
            default: ;  // unknown actions are dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side. Inputs move on the falling edge; acceptance is seen at
    // the rising edge. send_beat returns right after the accepting edge, so
    // anything that waits must first drop in_valid at the next falling edge.
    // ------------------------------------------------------------------
    task automatic send_beat(spat_pkg::in_beat_t b);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = b;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_beat(b);
        beats_sent++;
    endtask

    task automatic load_entry(spat_pkg::action_t act, int unsigned idx, logic [63:0] value);
        spat_pkg::in_beat_t b;
        b             = random_beat();
        b.action      = act;
        b.entry_index = 10'(idx);
        b.entry_value = value;
        send_beat(b);
    endtask

    task automatic translate_beat(logic [31:0] offset, logic [15:0] sel);
        spat_pkg::in_beat_t b;
        b                 = random_beat();
        b.action          = spat_pkg::ACT_TRANSLATE;
        b.logical_address = offset;
        b.selector        = sel;
        send_beat(b);
    endtask

    // Stop offering, let every queued result drain, then let loads settle
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_translations.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Called on a falling edge with the block idle
    task automatic write_count(spat_pkg::cfg_reg_t which,
                               logic [spat_pkg::CFG_DATA_W-1:0] raw);
        cfg_write = 1'b1;
        cfg_index = which;
        cfg_data  = raw;
        case (which)
            spat_pkg::CFG_GLOBAL_COUNT: global_count    = raw[spat_pkg::DESC_CNT_W-1:0];
            spat_pkg::CFG_LOCAL_COUNT:  local_count     = raw[spat_pkg::DESC_CNT_W-1:0];
            spat_pkg::CFG_DIR_COUNT:    directory_count = raw[spat_pkg::PAGE_CNT_W-1:0];
            spat_pkg::CFG_PAGE_COUNT:   page_count      = raw[spat_pkg::PAGE_CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // New counts, then load every entry now in reach that was never loaded
    task automatic set_counts(logic [spat_pkg::CFG_DATA_W-1:0] g, l, d, p);
        int unsigned i;
        wait_drained();
        write_count(spat_pkg::CFG_GLOBAL_COUNT, g);
        write_count(spat_pkg::CFG_LOCAL_COUNT, l);
        write_count(spat_pkg::CFG_DIR_COUNT, d);
        write_count(spat_pkg::CFG_PAGE_COUNT, p);
        for (i = 0; i < clip_count(global_count, spat_pkg::DESC_DEPTH_DEF); i++)
            if (!gdt_loaded[i])
                load_entry(spat_pkg::ACT_LOAD_GLOBAL, i, rand64());
        for (i = 0; i < clip_count(local_count, spat_pkg::DESC_DEPTH_DEF); i++)
            if (!ldt_loaded[i])
                load_entry(spat_pkg::ACT_LOAD_LOCAL, i, rand64());
        for (i = 0; i < clip_count(directory_count, spat_pkg::PAGE_DEPTH_DEF); i++)
            if (!dir_loaded[i])
                load_entry(spat_pkg::ACT_LOAD_DIR, i, rand64());
        for (i = 0; i < clip_count(page_count, spat_pkg::PAGE_DEPTH_DEF); i++)
            if (!pte_loaded[i])
                load_entry(spat_pkg::ACT_LOAD_PAGE, i, rand64());
    endtask

    task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // Mostly mapped walks: pick a target linear address (inside the counts where they
    // are nonzero), load a descriptor whose base and limit land on it, make the directory
    // and page entries present most of the time, then translate. The rest is noise.
    task automatic run_random(int unsigned n);
        int unsigned        done_beats;
        int unsigned        ncnt;
        int unsigned        slot;
        int unsigned        dcap;
        int unsigned        pcap;
        int unsigned        dir;
        int unsigned        pg;
        int unsigned        pick;
        logic               use_ldt;
        logic               gran;
        logic [19:0]        lim;
        logic [31:0]        span;
        logic [31:0]        off;
        logic [31:0]        lin;
        logic [15:0]        sel;
        spat_pkg::in_beat_t b;
        done_beats = 0;
        while (done_beats < n)
        begin
            use_ldt = 1'($urandom_range(0, 1));
            ncnt = clip_count(use_ldt ? local_count : global_count, spat_pkg::DESC_DEPTH_DEF);
            if ($urandom_range(0, 99) < 70 && ncnt >= (use_ldt ? 1 : 2))
            begin
                slot = use_ldt ? $urandom_range(0, ncnt - 1) : $urandom_range(1, ncnt - 1);
                dcap = clip_count(directory_count, spat_pkg::PAGE_DEPTH_DEF);
                pcap = clip_count(page_count, spat_pkg::PAGE_DEPTH_DEF);
                dir  = (dcap != 0) ? $urandom_range(0, dcap - 1) : $urandom_range(0, 1023);
                pg   = (pcap != 0) ? $urandom_range(0, pcap - 1) : $urandom_range(0, 1023);
                lin  = {10'(dir), 10'(pg), 12'($urandom)};
                gran = 1'($urandom_range(0, 1));
                lim  = ($urandom_range(0, 3) == 0) ? 20'hFFFFF : 20'($urandom);
                span = gran ? {lim, 12'hFFF} : {12'h000, lim};
                pick = $urandom_range(0, 9);
                // right at the limit, one past it, or anywhere inside
                if (pick == 0)
                    off = span;
                else if (pick == 1)
                    off = span + 32'd1;
                else
                    off = $urandom_range(0, span);
                if ($urandom_range(0, 4) != 0)
                    load_entry(spat_pkg::ACT_LOAD_DIR, dir,
                               make_pte(20'($urandom), $urandom_range(0, 9) != 0));
                if ($urandom_range(0, 4) != 0)
                    load_entry(spat_pkg::ACT_LOAD_PAGE, pg,
                               make_pte(20'($urandom), $urandom_range(0, 9) != 0));
                load_entry(use_ldt ? spat_pkg::ACT_LOAD_LOCAL : spat_pkg::ACT_LOAD_GLOBAL,
                           slot,
                           make_descriptor(lin - off, lim, $urandom_range(0, 9) != 0, gran));
                sel = {13'(slot), use_ldt, 2'($urandom)};
                translate_beat(off, sel);
                done_beats += 4;
                if ($urandom_range(0, 1) == 1)
                begin
                    translate_beat($urandom_range(0, span), sel);
                    done_beats++;
                end
            end
            else
            begin
                b = random_beat();
                if ($urandom_range(0, 1) == 1)
                begin
                    b.action = spat_pkg::ACT_TRANSLATE;
                    // near the counts half the time, else anywhere
                    if ($urandom_range(0, 1) == 1)
                        b.selector = {13'($urandom_range(0, 300)), 3'($urandom)};
                    if ($urandom_range(0, 1) == 1)
                        b.logical_address = 32'($urandom_range(0, 16'hFFFF));
                end
                send_beat(b);
                done_beats++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Counts are zero out of reset: every translate faults on the index check
    task automatic test_empty_counts();
        set_idling(19, 59);
        translate_beat(32'h0000_0000, 16'h0004);  // local slot 0, count 0
        translate_beat(32'h0000_0000, 16'h0000);  // null global
        translate_beat(32'hFFFF_FFFF, 16'hFFFB);  // global slot 8191
    endtask

    // Each fault path, the mapped path, wrap of base + offset, and ignored beats
    task automatic test_segment_checks();
        spat_pkg::in_beat_t b;
        set_counts(11'd4, 11'd4, 11'd4, 11'd8);
        load_entry(spat_pkg::ACT_LOAD_DIR, 0, make_pte(20'($urandom), 1'b1));
        load_entry(spat_pkg::ACT_LOAD_DIR, 1, make_pte(20'($urandom), 1'b0));
        load_entry(spat_pkg::ACT_LOAD_PAGE, 0, make_pte(20'hABCDE, 1'b1));
        load_entry(spat_pkg::ACT_LOAD_PAGE, 1, make_pte(20'($urandom), 1'b0));
        load_entry(spat_pkg::ACT_LOAD_PAGE, 7, 64'hFFFF_FFFF_FFFF_FFFF);
        load_entry(spat_pkg::ACT_LOAD_GLOBAL, 1,
                   make_descriptor(32'h0000_0000, 20'h01FFF, 1'b1, 1'b0));
        load_entry(spat_pkg::ACT_LOAD_GLOBAL, 2,
                   make_descriptor(32'hFFFF_F000, 20'hFFFFF, 1'b1, 1'b1));
        load_entry(spat_pkg::ACT_LOAD_GLOBAL, 3,
                   make_descriptor(32'h0000_0000, 20'hFFFFF, 1'b0, 1'b1));
        load_entry(spat_pkg::ACT_LOAD_LOCAL, 0,
                   make_descriptor(32'h0040_0000, 20'hFFFFF, 1'b1, 1'b1));
        load_entry(spat_pkg::ACT_LOAD_LOCAL, 1,
                   make_descriptor(32'h0000_2000, 20'hFFFFF, 1'b1, 1'b0));
        translate_beat(32'h0000_0123, 16'h0008);  // mapped through page 0
        translate_beat(32'h0000_1FFF, 16'h0008);  // offset == limit, page absent
        translate_beat(32'h0000_2000, 16'h0008);  // one past the limit
        translate_beat(32'h0000_0000, 16'h0003);  // null global, nonzero low bits
        translate_beat(32'h0000_0000, 16'h0018);  // segment not present
        translate_beat(32'h0000_0000, 16'h0020);  // global slot at the count
        translate_beat(32'h0000_17FF, 16'h0010);  // base + offset wraps to page 0
        translate_beat(32'hFFFF_FFFF, 16'h0010);  // directory index past count
        translate_beat(32'h0000_0005, 16'h0004);  // directory entry absent
        translate_beat(32'h0000_5123, 16'h000C);  // all-ones frame
        translate_beat(32'h0001_0000, 16'h000C);  // page index past count
        translate_beat(32'h000F_FFFF, 16'h000C);  // byte limit exactly, page past count
        translate_beat(32'hFFFF_FFFF, 16'hFFFF);  // max selector
        b = random_beat();
        b.action = ACT_UNKNOWN_LO;
        send_beat(b);
        b = random_beat();
        b.action = ACT_UNKNOWN_HI;
        send_beat(b);
        // slot 257 is past the store; global 1 must survive
        load_entry(spat_pkg::ACT_LOAD_GLOBAL, 257,
                   make_descriptor(32'h0, 20'h0, 1'b0, 1'b0));
        translate_beat(32'h0000_0000, 16'h0008);
    endtask

    task automatic test_mixed_traffic();
        set_idling(19, 59);
        set_counts(11'd40, 11'd24, 11'd16, 11'd64);
        run_random(180);
        // larger counts, the roles of the two sides swapped
        set_idling(59, 19);
        set_counts(11'd48, 11'd32, 11'd24, 11'd80);
        run_random(150);
    endtask

    // Bits above a register's width are dropped, and a count past the store
    // depth stops at the depth
    task automatic test_count_masking();
        set_idling(0, 0);
        set_counts(11'h603, 11'h200, 11'd24, 11'd80);  // global 3, local 0
        run_random(40);
        // global 511 caps at 256; only loaded slots and slots past the depth are used
        wait_drained();
        write_count(spat_pkg::CFG_GLOBAL_COUNT, 11'h7FF);
        translate_beat(32'($urandom_range(0, 16'hFFFF)), 16'h0008);
        translate_beat(32'($urandom_range(0, 16'hFFFF)), 16'h0010);
        translate_beat(32'h0000_0000, 16'h0800);  // slot 256, first past the depth
        translate_beat(32'h0000_0000, 16'h0FF8);  // slot 511, at the count
        translate_beat(32'h0000_0000, 16'h1000);  // slot 512, past both
    endtask

    // Receiver holds off while the sender keeps offering; the input must stall
    task automatic test_backpressure();
        set_idling(0, 0);
        set_counts(11'd2, 11'd1, 11'd1, 11'd1);
        @(negedge clk);
        ready_hold_left = 300;
        run_random(40);
        wait_drained();
        set_counts(11'd3, 11'd1, 11'd0, 11'd1);
        run_random(60);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (ready_hold_left != 0)
            begin
                out_ready = 1'b0;
                ready_hold_left--;
            end
            else
                out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 100)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        spat_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_translations.size() == 0)
                flag_mismatch($sformatf("unexpected result beat %h", out_data));
            else
            begin
                want = expected_translations.pop_front();
                translations_checked++;
                if (want.fault)
                    faults_seen++;
                if (out_data.physical_address !== want.physical_address)
                    flag_mismatch($sformatf("physical_address got %h want %h",
                                            out_data.physical_address,
                                            want.physical_address));
                if (out_data.fault !== want.fault)
                    flag_mismatch($sformatf("fault got %b want %b",
                                            out_data.fault, want.fault));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_translations.size());
            $display("[segmented_paged_address_translator_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_counts();
        test_segment_checks();
        test_mixed_traffic();
        test_count_masking();
        test_backpressure();
        wait_drained();
        $display("%0d beats sent, %0d translations checked (%0d faulted, %0d mapped)",
                 beats_sent, translations_checked, faults_seen,
                 translations_checked - faults_seen);
        $display("counts from zero through masked and past-depth values; one long result stall");
        if (mismatches == 0)
            $display("[segmented_paged_address_translator_core] OK");
        else
            $display("[segmented_paged_address_translator_core] ERROR");
        $finish;
    end

endmodule
